@@ hdl/qarl_pkg.sv @@
// Shared widths, constants and codes of the query admission rate limiter.
package qarl_pkg;

    localparam int TIME_W    = 48;
    localparam int ADDR_W    = 32;
    localparam int NONCE_W   = 64;
    localparam int RATE_W    = 5;
    localparam int VERDICT_W = 3;

    localparam int QARL_MAX_PER_WINDOW = 16;
    localparam int QARL_SOURCE_SLOTS   = 16;
    localparam int QARL_NONCE_SLOTS    = 64;

    localparam logic [TIME_W:0] NONCE_AGE_MS = (TIME_W+1)'(10000);
    localparam logic [TIME_W:0] STAMP_AGE_MS = (TIME_W+1)'(1000);

    localparam logic [RATE_W-1:0] RATE_LIMIT_RESET = RATE_W'(10);

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ADMIT   = 3'd0,
        VERDICT_GLOBAL  = 3'd1,
        VERDICT_REPLAY  = 3'd2,
        VERDICT_SOURCE  = 3'd3,
        VERDICT_FULL    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic match;
        logic free;
        logic over_rate;
        logic full;
    } src_stat_t;

    typedef struct packed {
        logic match;
        logic free;
        logic recent;
    } nonce_stat_t;

endpackage

@@ hdl/qarl_if.sv @@
// Handshake channels for query words and verdict words.
interface qarl_query_if
    import qarl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    now_ms;
    logic [ADDR_W-1:0]    source_addr;
    logic [NONCE_W-1:0]   nonce;

    modport source (output valid, output now_ms, output source_addr, output nonce,
                    input ready);
    modport sink   (input valid, input now_ms, input source_addr, input nonce,
                    output ready);
endinterface

interface qarl_verdict_if
    import qarl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VERDICT_W-1:0]  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

@@ hdl/qarl_stamp_chain.sv @@
// Oldest-first chain of stamp cells; the head ages out and the rest shift down.
module qarl_stamp_chain
    import qarl_pkg::*;
#(
    parameter int DEPTH = QARL_MAX_PER_WINDOW,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              age_en,
    input  logic              push,
    input  logic [TIME_W-1:0] now,
    output logic [CW-1:0]     count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [TIME_W-1:0] stamps_reg [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              pop;

    always_comb
    begin
        pop = age_en && (count_reg != '0) &&
              ({1'b0, now} >= ({1'b0, stamps_reg[0]} + STAMP_AGE_MS));
        count_next = count_reg;
        if (pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // shift every stamp one cell towards the head on a drop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                stamps_reg[i] <= stamps_reg[i+1];
            end
        end
        else if (push)
        begin
            stamps_reg[count_reg[IW-1:0]] <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

@@ hdl/qarl_source_cell.sv @@
// One source slot: its address and its one-second stamp chain.
module qarl_source_cell
    import qarl_pkg::*;
#(
    parameter int DEPTH = QARL_MAX_PER_WINDOW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              age_en,
    input  logic              push,
    input  logic [TIME_W-1:0] now,
    input  logic [ADDR_W-1:0] q_addr,
    input  logic [RATE_W-1:0] rate,
    output src_stat_t         stat
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [ADDR_W-1:0] addr_reg;
    logic [CW-1:0]     count;
    logic              live;

    qarl_stamp_chain #(.DEPTH(DEPTH)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .age_en (age_en),
        .push   (push),
        .now    (now),
        .count  (count)
    );

    // a slot holds a source exactly while it has stamps
    assign live = (count != '0);

    always_ff @(posedge clk)
    begin
        if (push && !live)
        begin
            addr_reg <= q_addr;
        end
    end

    always_comb
    begin
        stat.match     = live && (addr_reg == q_addr);
        stat.free      = !live;
        stat.over_rate = 32'(count) >= 32'(rate);
        stat.full      = 32'(count) >= 32'(DEPTH);
    end

endmodule

@@ hdl/qarl_nonce_cell.sv @@
// One nonce slot of the ten-second replay cache.
module qarl_nonce_cell
    import qarl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               age_en,
    input  logic               write,
    input  logic [TIME_W-1:0]  now,
    input  logic [NONCE_W-1:0] q_nonce,
    output nonce_stat_t        stat
);

    logic [NONCE_W-1:0] value_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               valid_reg;
    logic               aged;

    assign aged = {1'b0, now} >= ({1'b0, time_reg} + NONCE_AGE_MS);

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            value_reg <= q_nonce;
            time_reg  <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (write)
        begin
            valid_reg <= 1'b1;
        end
        else if (age_en && valid_reg && aged)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.match  = valid_reg && (value_reg == q_nonce);
        stat.free   = !valid_reg;
        stat.recent = (time_reg != '0);
    end

endmodule

@@ hdl/query_admission_rate_limiter.sv @@
// After a query is accepted the controller ages the stamp chains in S_AGE, latches the
// slot flags in S_SCAN, registers the verdict in S_DECIDE and presents it in S_OUT; no new
// query is accepted until the verdict is taken.
// Reset clears all slot counts, nonce valid bits and the control state, and loads
// rate_limit with 10; no clearing pass is needed.
module query_admission_rate_limiter
    import qarl_pkg::*;
#(
    parameter int MAX_PER_WINDOW = QARL_MAX_PER_WINDOW,
    parameter int SOURCE_SLOTS   = QARL_SOURCE_SLOTS,
    parameter int NONCE_SLOTS    = QARL_NONCE_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_wdata,
    qarl_query_if.sink        query,
    qarl_verdict_if.source    result
);

    localparam int CW = $clog2(MAX_PER_WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       age_cnt_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [NONCE_W-1:0]  nonce_reg;
    logic [VERDICT_W-1:0] verdict_reg;

    logic                age_en;
    logic                admit;
    verdict_t            verdict_next;
    logic [CW-1:0]       gcount;

    src_stat_t           s_stat [SOURCE_SLOTS];
    nonce_stat_t         n_stat [NONCE_SLOTS];

    logic [SOURCE_SLOTS-1:0] sm_reg, sf_reg, so_reg, sx_reg;
    logic [NONCE_SLOTS-1:0]  nm_reg, nf_reg, nr_reg;
    logic [SOURCE_SLOTS-1:0] s_first, sf_first, s_push;
    logic [NONCE_SLOTS-1:0]  n_first, nf_first, n_write;

    assign age_en = (state_reg == S_AGE);

    qarl_stamp_chain #(.DEPTH(MAX_PER_WINDOW)) u_global (
        .clk    (clk),
        .rst_n  (rst_n),
        .age_en (age_en),
        .push   (admit),
        .now    (now_reg),
        .count  (gcount)
    );

    for (genvar s = 0; s < SOURCE_SLOTS; s++)
    begin : g_src
        qarl_source_cell #(.DEPTH(MAX_PER_WINDOW)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .age_en (age_en),
            .push   (s_push[s]),
            .now    (now_reg),
            .q_addr (addr_reg),
            .rate   (rate_reg),
            .stat   (s_stat[s])
        );
    end

    for (genvar n = 0; n < NONCE_SLOTS; n++)
    begin : g_nonce
        qarl_nonce_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .age_en  (age_en),
            .write   (n_write[n]),
            .now     (now_reg),
            .q_nonce (nonce_reg),
            .stat    (n_stat[n])
        );
    end

    // lowest set bit picks the first slot, as a linear search would
    always_comb
    begin
        s_first  = sm_reg & (~sm_reg + SOURCE_SLOTS'(1));
        sf_first = sf_reg & (~sf_reg + SOURCE_SLOTS'(1));
        n_first  = nm_reg & (~nm_reg + NONCE_SLOTS'(1));
        nf_first = nf_reg & (~nf_reg + NONCE_SLOTS'(1));

        if (32'(gcount) >= 32'(rate_reg))
        begin
            verdict_next = VERDICT_GLOBAL;
        end
        else if (|(n_first & nr_reg))
        begin
            verdict_next = VERDICT_REPLAY;
        end
        else if (|(s_first & so_reg))
        begin
            verdict_next = VERDICT_SOURCE;
        end
        else if ((32'(gcount) >= 32'(MAX_PER_WINDOW)) ||
                 (sm_reg == '0 && sf_reg == '0) ||
                 (|(s_first & sx_reg)) ||
                 (nm_reg == '0 && nf_reg == '0))
        begin
            verdict_next = VERDICT_FULL;
        end
        else
        begin
            verdict_next = VERDICT_ADMIT;
        end

        admit   = (state_reg == S_DECIDE) && (verdict_next == VERDICT_ADMIT);
        s_push  = admit ? ((sm_reg != '0) ? s_first : sf_first) : '0;
        n_write = admit ? ((nm_reg != '0) ? n_first : nf_first) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (query.valid && query.ready)
        begin
            now_reg   <= query.now_ms;
            addr_reg  <= query.source_addr;
            nonce_reg <= query.nonce;
        end
        if (state_reg == S_SCAN)
        begin
            for (int s = 0; s < SOURCE_SLOTS; s++)
            begin
                sm_reg[s] <= s_stat[s].match;
                sf_reg[s] <= s_stat[s].free;
                so_reg[s] <= s_stat[s].over_rate;
                sx_reg[s] <= s_stat[s].full;
            end
            for (int n = 0; n < NONCE_SLOTS; n++)
            begin
                nm_reg[n] <= n_stat[n].match;
                nf_reg[n] <= n_stat[n].free;
                nr_reg[n] <= n_stat[n].recent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            age_cnt_reg <= '0;
            rate_reg    <= RATE_LIMIT_RESET;
            verdict_reg <= VERDICT_ADMIT;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    age_cnt_reg <= '0;
                    if (query.valid)
                    begin
                        state_reg <= S_AGE;
                    end
                end
                S_AGE:
                begin
                    // one head drop per chain per cycle; enough cycles to empty a full chain
                    age_cnt_reg <= age_cnt_reg + CW'(1);
                    if (age_cnt_reg == CW'(MAX_PER_WINDOW - 1))
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    verdict_reg <= verdict_next;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (result.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign query.ready    = (state_reg == S_IDLE);
    assign result.valid   = (state_reg == S_OUT);
    assign result.verdict = verdict_reg;

endmodule
